### design/fixed_point_newton_sqrt_defines.svh
// Assertion macros used by the top-level file of this block.
`ifndef FIXED_POINT_NEWTON_SQRT_DEFINES_SVH
`define FIXED_POINT_NEWTON_SQRT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fnsqrt check failed");

// The consequent must hold in the cycle after the antecedent.
`define FNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fnsqrt check failed");

`endif

### design/fnsqrt_pkg.sv
`timescale 1ns / 1ps

package fnsqrt_pkg;

    localparam int FracBits      = 5;
    localparam int MaxIterations = 48;
    localparam int RadW          = 32;
    localparam int QuotW         = RadW + FracBits;
    localparam int DivCntW       = $clog2(QuotW);
    localparam int IterW         = $clog2(MaxIterations);

    localparam int SmallLimit    = 1000;
    localparam int SmallShift    = 4;
    localparam int LargeShift    = 8;
    localparam int ConvergedDiff = 1;

    localparam logic [RadW-1:0] FixedOne = RadW'(1) << FracBits;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_run;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic converged;
    } t_dp_sts;

    // Starting guess: a coarse shift of the raw value, never below 1.0.
    function automatic logic [RadW-1:0] seed_guess(input logic [RadW-1:0] rad);
        logic [RadW-1:0] s;
        if (rad < RadW'(SmallLimit)) begin
            s = rad >> SmallShift;
        end else begin
            s = rad >> LargeShift;
        end
        if (s < FixedOne) begin
            s = FixedOne;
        end
        return s;
    endfunction

endpackage

### design/fnsqrt_dp.sv
`timescale 1ns / 1ps

module fnsqrt_dp (
    input  logic                             i_clk,
    input  fnsqrt_pkg::t_dp_cmd              i_cmd,
    input  logic [fnsqrt_pkg::RadW-1:0]      i_rad,
    output fnsqrt_pkg::t_dp_sts              o_sts,
    output logic [fnsqrt_pkg::RadW-1:0]      o_root,
    output logic                             o_capped
);

    logic [fnsqrt_pkg::RadW-1:0]    r_rad;
    logic [fnsqrt_pkg::RadW-1:0]    r_guess;
    logic [fnsqrt_pkg::QuotW-1:0]   r_dvd;
    logic [fnsqrt_pkg::RadW-1:0]    r_rem;
    logic [fnsqrt_pkg::DivCntW-1:0] r_cnt;
    logic                           r_conv;
    logic [fnsqrt_pkg::RadW-1:0]    r_out_root;
    logic                           r_out_capped;

    logic [fnsqrt_pkg::RadW:0]      w_rem_sh;
    logic [fnsqrt_pkg::RadW:0]      w_rem_sub;
    logic                           w_fits;
    logic [fnsqrt_pkg::QuotW-1:0]   w_quot;
    logic [fnsqrt_pkg::QuotW:0]     w_sum;
    logic [fnsqrt_pkg::RadW-1:0]    w_new;
    logic [fnsqrt_pkg::RadW-1:0]    w_diff;
    logic                           w_conv;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of r_dvd from the top while the quotient bits shift in at the bottom.
    assign w_rem_sh  = {r_rem, r_dvd[fnsqrt_pkg::QuotW-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_guess};
    assign w_fits    = (w_rem_sh >= {1'b0, r_guess});

    // A zero divisor gives an all-ones 32-bit quotient.
    assign w_quot = (r_guess == '0) ? fnsqrt_pkg::QuotW'({fnsqrt_pkg::RadW{1'b1}}) : r_dvd;
    assign w_sum  = {1'b0, fnsqrt_pkg::QuotW'(r_guess)} + {1'b0, w_quot};
    assign w_new  = w_sum[fnsqrt_pkg::RadW:1];
    assign w_diff = r_guess - w_new;
    assign w_conv = (w_diff <= fnsqrt_pkg::RadW'(fnsqrt_pkg::ConvergedDiff));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rad   <= i_rad;
            r_guess <= fnsqrt_pkg::seed_guess(i_rad);
        end
        if (i_cmd.div_start) begin
            r_dvd <= fnsqrt_pkg::QuotW'(r_rad) << fnsqrt_pkg::FracBits;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_run) begin
            r_dvd <= {r_dvd[fnsqrt_pkg::QuotW-2:0], w_fits};
            r_rem <= w_fits ? w_rem_sub[fnsqrt_pkg::RadW-1:0]
                            : w_rem_sh[fnsqrt_pkg::RadW-1:0];
            r_cnt <= r_cnt + fnsqrt_pkg::DivCntW'(1);
        end
        if (i_cmd.step) begin
            r_guess <= w_new;
            r_conv  <= w_conv;
        end
        if (i_cmd.out_load) begin
            r_out_root   <= r_guess;
            r_out_capped <= ~r_conv;
        end
    end

    assign o_sts.div_last  = (r_cnt == fnsqrt_pkg::DivCntW'(fnsqrt_pkg::QuotW - 1));
    assign o_sts.converged = w_conv;
    assign o_root          = r_out_root;
    assign o_capped        = r_out_capped;

endmodule

### design/fnsqrt_ctrl.sv
`timescale 1ns / 1ps

module fnsqrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  fnsqrt_pkg::t_dp_sts i_sts,
    output fnsqrt_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [fnsqrt_pkg::IterW-1:0] r_iter;
    logic [fnsqrt_pkg::IterW-1:0] n_iter;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic                         w_at_cap;

    assign w_at_cap = (r_iter == fnsqrt_pkg::IterW'(fnsqrt_pkg::MaxIterations - 1));

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_iter          = '0;
                    n_state         = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_run = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.converged || w_at_cap) begin
                    n_state = S_FIN;
                end else begin
                    n_iter  = r_iter + fnsqrt_pkg::IterW'(1);
                    n_state = S_LOAD;
                end
            end
            S_FIN: begin
                // Wait here only while the previous result is still unclaimed.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/fixed_point_newton_sqrt.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// s       | in        | i_s_tvalid / o_s_tready | i_s_tdata: radicand [31:0]
// m       | out       | o_m_tvalid / i_m_tready | o_m_tdata: root [31:0]; o_m_tuser: capped
//
// Each Newton step loads the shared bit-serial divider, runs it over every
// quotient bit and then updates the guess. An item runs from 1 to 48 steps,
// ending early once the guess converges. Reset is synchronous and active
// low; it clears the controller and empties the output register. A stalled
// result holds in the output register while the next transaction is taken
// and worked on; only its hand-off waits.

`include "fixed_point_newton_sqrt_defines.svh"

module fixed_point_newton_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [fnsqrt_pkg::RadW-1:0]   i_s_tdata,   // [31:0] radicand
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [fnsqrt_pkg::RadW-1:0]   o_m_tdata,   // [31:0] root
    output logic                          o_m_tuser    // [0] capped
);

    fnsqrt_pkg::t_dp_cmd w_cmd;
    fnsqrt_pkg::t_dp_sts w_sts;

    fnsqrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fnsqrt_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_rad    (i_s_tdata),
        .o_sts    (w_sts),
        .o_root   (o_m_tdata),
        .o_capped (o_m_tuser)
    );

    `FNS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `FNS_ASSERT_SAME(a_valid_from_load, i_clk, i_rst_n, $rose(o_m_tvalid), $past(w_cmd.out_load))
    `FNS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_m_tvalid || i_m_tready)

endmodule

### bench/fixed_point_newton_sqrt_tb.sv
`timescale 1ns / 1ps

module fixed_point_newton_sqrt_tb;

    localparam int RandomItems = 650;
    // The limit covers the slowest item, which runs to the step cap, for every
    // item plus stalls, gaps and the long hold-off, several times over.
    localparam int CycleLimit  = 6_000_000;
    localparam int DrainCycles = 2000;
    localparam int HoldCycles  = 5000;

    typedef struct packed {
        logic [fnsqrt_pkg::RadW-1:0] root;
        logic                        capped;
    } t_sqrt_result;

    class sqrt_scoreboard;
        t_sqrt_result expected_roots[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Newton-Raphson iteration with a widened dividend, as the block does it.
        static function t_sqrt_result predict_root(logic [fnsqrt_pkg::RadW-1:0] rad);
            logic [fnsqrt_pkg::RadW-1:0] est;
            logic [fnsqrt_pkg::RadW-1:0] prev;
            logic [63:0]                 dividend;
            logic [63:0]                 quot;
            logic                        converged;
            t_sqrt_result                res;
            est = rad >> ((rad < fnsqrt_pkg::RadW'(fnsqrt_pkg::SmallLimit))
                          ? fnsqrt_pkg::SmallShift : fnsqrt_pkg::LargeShift);
            if (est < fnsqrt_pkg::FixedOne) begin
                est = fnsqrt_pkg::FixedOne;
            end
            dividend  = {32'b0, rad} << fnsqrt_pkg::FracBits;
            converged = 1'b0;
            for (int n = 0; n < fnsqrt_pkg::MaxIterations && !converged; n++) begin
                prev = est;
                quot = (est == '0) ? 64'hFFFF_FFFF : dividend / {32'b0, est};
                est  = fnsqrt_pkg::RadW'(({32'b0, est} + quot) >> 1);
                // A growing guess wraps the difference to a large value.
                if (fnsqrt_pkg::RadW'(prev - est)
                        <= fnsqrt_pkg::RadW'(fnsqrt_pkg::ConvergedDiff)) begin
                    converged = 1'b1;
                end
            end
            res.root   = est;
            res.capped = !converged;
            return res;
        endfunction

        function void note_radicand(logic [fnsqrt_pkg::RadW-1:0] rad);
            expected_roots.push_back(predict_root(rad));
        endfunction

        task report_mismatch(string what);
            if (mismatch_count < 200) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
            mismatch_count++;
        endtask

        task check_root(logic [fnsqrt_pkg::RadW-1:0] root, logic capped);
            t_sqrt_result want;
            if (expected_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%h capped=%b", root, capped));
            end else begin
                want = expected_roots.pop_front();
                if (root !== want.root) begin
                    report_mismatch($sformatf("root %h, expected %h", root, want.root));
                end
                if (capped !== want.capped) begin
                    report_mismatch($sformatf("capped %b, expected %b (root %h)",
                                              capped, want.capped, want.root));
                end
            end
        endtask

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [fnsqrt_pkg::RadW-1:0] i_s_tdata  = '0;   // [31:0] radicand
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [fnsqrt_pkg::RadW-1:0] o_m_tdata;         // [31:0] root
    logic                        o_m_tuser;         // [0] capped

    sqrt_scoreboard sb;
    int             tx_idle_pct     = 35;
    int             rx_idle_pct     = 35;
    bit             rx_hold_request = 1'b0;
    int             cycle_count     = 0;

    fixed_point_newton_sqrt DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Input and output transactions are taken from the values before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_radicand(i_s_tdata);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_root(o_m_tdata, o_m_tuser);
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_radicand(input logic [fnsqrt_pkg::RadW-1:0] rad);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rad;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [fnsqrt_pkg::RadW-1:0] pick_radicand();
        logic [fnsqrt_pkg::RadW-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 999);
            1:       v = $urandom_range(990, 1010);
            2:       v = $urandom_range(0, 65535);
            3:       v = (fnsqrt_pkg::RadW'(1) << $urandom_range(0, 31))
                         + fnsqrt_pkg::RadW'($urandom_range(0, 2)) - 1;
            4:       v = $urandom() | 32'hF000_0000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [fnsqrt_pkg::RadW-1:0] directed_q[$];
        t_sqrt_result                probe;
        sb = new();
        directed_q = '{32'd0, 32'd1, 32'd15, 32'd16, 32'd31, 32'd32, 32'd33, 32'd500,
                       32'd998, 32'd999, 32'd1000, 32'd1001, 32'd1024, 32'h0000_7FFF,
                       32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
                       32'hFFFF_FFFE, 32'hFFFF_FFFF};
        // Look for a radicand whose guess oscillates long enough to hit the cap.
        for (int unsigned r = 0; r < 20000; r++) begin
            probe = sqrt_scoreboard::predict_root(r);
            if (probe.capped) begin
                directed_q.push_back(r);
                break;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[k]) begin
            send_radicand(directed_q[k]);
        end

        for (int i = 0; i < RandomItems; i++) begin
            if (i == 150) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 300) begin
                tx_idle_pct = 35;
                rx_idle_pct = 35;
                // Let the block run dry before going on.
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) begin
                    @(posedge i_clk);
                end
            end
            if (i == 400) begin
                rx_hold_request = 1'b1;
            end
            send_radicand(pick_radicand());
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
